// ----- rtl/dv64_pkg.sv -----
package dv64_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	// action codes
	localparam logic ACT_UNSIGNED = 1'b0;
	localparam logic ACT_SIGNED   = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [DATA_WIDTH-1:0] dividend;
		logic [DATA_WIDTH-1:0] divisor;
	} div_in_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] quotient;
		logic [DATA_WIDTH-1:0] remainder;
	} div_out_t;

	// status from the shift-subtract core
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/dv64_core.sv -----
// restoring shift-subtract unit, one quotient bit per cycle
module dv64_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dv64_pkg::DATA_WIDTH-1:0] num,
	input  logic [dv64_pkg::DATA_WIDTH-1:0] den,
	output dv64_pkg::core_stat_t            stat,
	output logic [dv64_pkg::DATA_WIDTH-1:0] quo,
	output logic [dv64_pkg::DATA_WIDTH-1:0] rem
);

	localparam int W = dv64_pkg::DATA_WIDTH;
	localparam int CW = dv64_pkg::CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  qn_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  den_q;

	logic [W-1:0]  r_shift;
	logic [W:0]    diff;
	logic          take;
	logic          last;

	always_comb begin
		r_shift = {r_q[W-2:0], qn_q[W-1]};
		diff    = {r_q[W-1], r_shift} - {1'b0, den_q};
		// a carry out of the shift always exceeds the divisor
		take    = r_q[W-1] | ~diff[W];
		last    = (cnt_q == CW'(W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			qn_q  <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			qn_q <= {qn_q[W-2:0], take};
			r_q  <= take ? diff[W-1:0] : r_shift;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = qn_q;
	assign rem = r_q;

endmodule

// ----- rtl/divider_64_with_remainder.sv -----
// a taken request is registered, the core is started from the setup state, and the
// result is loaded into rsp once the core is done and the output slot is free; the single
//   shift-subtract unit retires one quotient bit per cycle (64 steps plus setup and finish)
// the block takes no request while a division is in flight or waits on the output slot
// reset: arst_n clears the sequencer and the result valid flag asynchronously
module divider_64_with_remainder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dv64_pkg::div_in_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dv64_pkg::div_out_t rsp
);

	localparam int W = dv64_pkg::DATA_WIDTH;

	dv64_pkg::state_t     state_q;
	dv64_pkg::state_t     state_d;

	// request as taken, kept for the whole division
	logic                 signed_q;
	logic [W-1:0]         a_q;
	logic [W-1:0]         b_q;
	logic                 neg_q;
	logic                 zero_q;

	// output register, parts the result from the next request
	logic                 rsp_valid_q;
	dv64_pkg::div_out_t   rsp_q;

	logic                 req_xfer;
	logic                 slot_free;
	logic                 load;
	logic                 core_start;
	logic [W-1:0]         mag_a;
	logic [W-1:0]         mag_b;
	logic                 neg_a;
	logic                 neg_b;
	dv64_pkg::core_stat_t core_stat;
	logic [W-1:0]         core_quo;
	logic [W-1:0]         core_rem;
	dv64_pkg::div_out_t   result;

	assign req_xfer  = req_valid && req_ready;
	// the output slot can take a result if empty or being drained this cycle
	assign slot_free = !rsp_valid_q || rsp_ready;

	// operand magnitudes for signed mode
	always_comb begin
		neg_a = signed_q && a_q[W-1];
		neg_b = signed_q && b_q[W-1];
		mag_a = neg_a ? (W'(0) - a_q) : a_q;
		mag_b = neg_b ? (W'(0) - b_q) : b_q;
	end

	// final quotient sign and the zero-divisor and signed-mode overrides
	always_comb begin
		if (zero_q) begin
			result.quotient = '0;
		end else if (neg_q) begin
			result.quotient = W'(0) - core_quo;
		end else begin
			result.quotient = core_quo;
		end
		if (zero_q || signed_q) begin
			result.remainder = '0;
		end else begin
			result.remainder = core_rem;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		core_start = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			dv64_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = dv64_pkg::ST_SETUP;
				end
			end
			dv64_pkg::ST_SETUP: begin
				core_start = 1'b1;
				state_d    = dv64_pkg::ST_RUN;
			end
			dv64_pkg::ST_RUN: begin
				if (core_stat.done) begin
					if (slot_free) begin
						load    = 1'b1;
						state_d = dv64_pkg::ST_IDLE;
					end else begin
						state_d = dv64_pkg::ST_DONE;
					end
				end
			end
			dv64_pkg::ST_DONE: begin
				// core keeps its result until the next start
				if (slot_free) begin
					load    = 1'b1;
					state_d = dv64_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dv64_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dv64_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			signed_q <= (req.action == dv64_pkg::ACT_SIGNED);
			a_q      <= req.dividend;
			b_q      <= req.divisor;
		end
		if (core_start) begin
			neg_q  <= neg_a ^ neg_b;
			zero_q <= (b_q == '0);
		end
		if (load) begin
			rsp_q <= result;
		end
	end

	dv64_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.num    (mag_a),
		.den    (mag_b),
		.stat   (core_stat),
		.quo    (core_quo),
		.rem    (core_rem)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the core only finishes while the sequencer waits on it
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.done |-> state_q == dv64_pkg::ST_RUN)
		else $error("core finished outside of run state");

	// the core is busy as the run phase begins
	a_busy_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dv64_pkg::ST_SETUP |=> core_stat.busy)
		else $error("core not started after setup");

	// signed results carry no remainder
	a_signed_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load && signed_q |=> rsp_q.remainder == '0)
		else $error("signed result with nonzero remainder");

	// a zero divisor yields a zero quotient
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		load && zero_q |=> rsp_q.quotient == '0)
		else $error("zero divisor gave nonzero quotient");

	// a result is never written over one not yet transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten before transfer");

endmodule

// ----- bench/tb_divider_64_with_remainder.sv -----
`timescale 1ns / 1ps

module tb_divider_64_with_remainder;

	typedef logic [dv64_pkg::DATA_WIDTH-1:0] word_t;

	// handy operand values
	localparam word_t ALL_ONES  = '1;
	localparam word_t MOST_NEG  = {1'b1, {(dv64_pkg::DATA_WIDTH-1){1'b0}}};
	localparam word_t MOST_POS  = {1'b0, {(dv64_pkg::DATA_WIDTH-1){1'b1}}};
	localparam word_t MINUS_ONE = '1;

	// directed part plus random part
	localparam int RANDOM_ITEMS = 1250;
	// the slowest legal run, with the longest gap, the division and the longest stall
	// for every item, still leaves plenty of headroom under this limit
	localparam int CYCLE_LIMIT = 1000000;
	// covers the time from request to result, with some margin
	localparam int DRAIN_CYCLES = 80;

	// one outstanding division: the request and the result it must produce
	typedef struct {
		dv64_pkg::div_in_t  request;
		dv64_pkg::div_out_t result;
	} pending_div_t;

	// keeps the divisions in flight and checks each returned result in order
	class division_scoreboard;
		pending_div_t awaited_results[$];
		int unsigned  mismatches;
		int unsigned  results_checked;

		function new();
			mismatches      = 0;
			results_checked = 0;
		endfunction

		// truncating division on the magnitudes, sign applied afterwards;
		// zero divisor gives all zeros, signed mode never returns a remainder
		function dv64_pkg::div_out_t quotient_and_remainder(dv64_pkg::div_in_t r);
			dv64_pkg::div_out_t res;
			word_t    mag_a;
			word_t    mag_b;
			word_t    quo;
			logic     neg_a;
			logic     neg_b;
			res = '0;
			if (r.action == dv64_pkg::ACT_UNSIGNED) begin
				if (r.divisor != '0) begin
					res.quotient  = r.dividend / r.divisor;
					res.remainder = r.dividend % r.divisor;
				end
			end else begin
				neg_a = r.dividend[dv64_pkg::DATA_WIDTH-1];
				neg_b = r.divisor[dv64_pkg::DATA_WIDTH-1];
				mag_a = neg_a ? word_t'(-r.dividend) : r.dividend;
				mag_b = neg_b ? word_t'(-r.divisor) : r.divisor;
				quo   = '0;
				if (mag_b != '0)
					quo = mag_a / mag_b;
				// most negative over minus one wraps back onto itself here
				if (neg_a != neg_b)
					quo = word_t'(-quo);
				res.quotient = quo;
			end
			return res;
		endfunction

		function void note_request(dv64_pkg::div_in_t r);
			pending_div_t p;
			p.request = r;
			p.result  = quotient_and_remainder(r);
			awaited_results.push_back(p);
		endfunction

		task report(string msg);
			if (mismatches < 40)
				$display("[%0t] MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		task check_response(dv64_pkg::div_out_t got);
			pending_div_t p;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result q=%h r=%h", got.quotient, got.remainder));
				return;
			end
			p = awaited_results.pop_front();
			results_checked++;
			if (got.quotient !== p.result.quotient)
				report($sformatf("quotient act=%b a=%h b=%h got %h want %h",
					p.request.action, p.request.dividend, p.request.divisor,
					got.quotient, p.result.quotient));
			if (got.remainder !== p.result.remainder)
				report($sformatf("remainder act=%b a=%h b=%h got %h want %h",
					p.request.action, p.request.dividend, p.request.divisor,
					got.remainder, p.result.remainder));
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               rsp_ready = 1'b0;
	dv64_pkg::div_in_t  req       = '0;
	logic               req_ready;
	logic               rsp_valid;
	dv64_pkg::div_out_t rsp;

	division_scoreboard board = new();

	dv64_pkg::div_in_t stimulus[$];
	int unsigned cycle_count   = 0;
	int unsigned signed_count  = 0;
	int unsigned zero_div_count = 0;

	divider_64_with_remainder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, board.awaited_results.size());
			$display("divider_64_with_remainder test failed");
			$finish;
		end
	end

	// result side: inputs only move at the rising edge, so a valid and ready pair
	// seen at the falling edge is a transfer at the next rising edge
	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_response(rsp);
	end

	// receiver back-pressure: each time mode_cycles wraps, switch between always ready,
	// ready dropped at random and long stall runs
	int unsigned ready_mode  = 0;
	int unsigned mode_cycles = 0;
	int unsigned stall_left  = 0;

	always @(posedge clk) begin
		if (mode_cycles == 599) begin
			mode_cycles <= 0;
			ready_mode  <= $urandom_range(0, 2);
		end else begin
			mode_cycles <= mode_cycles + 1;
		end
		case (ready_mode)
			0: begin
				rsp_ready <= 1'b1;
			end
			1: begin
				rsp_ready <= ($urandom_range(0, 2) != 0);
			end
			default: begin
				if (stall_left != 0) begin
					rsp_ready  <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 19) == 0)
						stall_left <= $urandom_range(1, 60);
				end
			end
		endcase
	end

	function automatic dv64_pkg::div_in_t make_req(logic act, word_t a, word_t b);
		dv64_pkg::div_in_t r;
		r.action   = act;
		r.dividend = a;
		r.divisor  = b;
		return r;
	endfunction

	// operands spread over leading-zero counts, small values, powers of two
	// and the corner values
	function automatic word_t random_operand();
		word_t v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 11))
			0, 1, 2, 3: ;
			4, 5, 6: v = v >> $urandom_range(1, dv64_pkg::DATA_WIDTH - 1);
			7: v = word_t'($urandom_range(0, 15));
			8: v = word_t'(1) << $urandom_range(0, dv64_pkg::DATA_WIDTH - 1);
			9: v = word_t'(-$urandom_range(1, 15));
			10: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = ALL_ONES;
					2: v = MOST_NEG;
					3: v = MOST_POS;
					default: v = word_t'(1);
				endcase
			end
			default: begin
				v = word_t'(1) << $urandom_range(0, dv64_pkg::DATA_WIDTH - 1);
				v = $urandom_range(0, 1) ? word_t'(-v) : v - 1;
			end
		endcase
		return v;
	endfunction

	// one request: raise valid with the payload, hold until the transfer
	// call at a rising edge; valid is left high for a following back-to-back item
	task automatic send_req(input dv64_pkg::div_in_t item);
		req_valid <= 1'b1;
		req       <= item;
		@(negedge clk);
		while (!req_ready)
			@(negedge clk);
		@(posedge clk);
		board.note_request(item);
		if (item.action == dv64_pkg::ACT_SIGNED)
			signed_count++;
		if (item.divisor == '0)
			zero_div_count++;
	endtask

	// play the whole stimulus queue in bursts with idle gaps between them
	task automatic drive_traffic();
		int unsigned burst;
		int unsigned gap;
		while (stimulus.size() != 0) begin
			burst = $urandom_range(1, 8);
			while (burst != 0 && stimulus.size() != 0) begin
				send_req(stimulus.pop_front());
				burst--;
			end
			// about a third of the bursts run straight into the next one
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0 || stimulus.size() == 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		dv64_pkg::div_in_t item;

		// hold reset, then release it on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unsigned corners
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, '0, '0));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, ALL_ONES, '0));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, word_t'(100), word_t'(7)));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, ALL_ONES, ALL_ONES));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, ALL_ONES, word_t'(1)));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, '0, word_t'(5)));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, word_t'(1), ALL_ONES));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, ALL_ONES, MOST_NEG));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, MOST_NEG, word_t'(2)));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, word_t'(12345),
			word_t'(1) << 20));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED, ALL_ONES, word_t'(3)));
		stimulus.push_back(make_req(dv64_pkg::ACT_UNSIGNED,
			{(dv64_pkg::DATA_WIDTH/2){2'b10}}, {(dv64_pkg::DATA_WIDTH/2){2'b01}}));
		// directed: signed corners, sign combinations and the wrapping case
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, '0, '0));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, word_t'(100), '0));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MOST_NEG, MINUS_ONE));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MOST_NEG, word_t'(1)));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, word_t'(-7), word_t'(2)));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, word_t'(7), word_t'(-2)));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, word_t'(-7), word_t'(-2)));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MOST_NEG, MOST_NEG));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MOST_POS, MINUS_ONE));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MINUS_ONE, MOST_NEG));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, word_t'(1), MINUS_ONE));
		stimulus.push_back(make_req(dv64_pkg::ACT_SIGNED, MOST_POS, word_t'(7)));

		// random part, both modes mixed evenly
		repeat (RANDOM_ITEMS) begin
			item.action   = $urandom_range(0, 1) ? dv64_pkg::ACT_SIGNED
				: dv64_pkg::ACT_UNSIGNED;
			item.dividend = random_operand();
			item.divisor  = random_operand();
			stimulus.push_back(item);
		end

		drive_traffic();

		// wait out every outstanding result, then a latency's worth of quiet
		// to catch anything extra the block might still send
		while (board.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d divisions, %0d signed and %0d with a zero divisor",
			board.results_checked, signed_count, zero_div_count);
		$display("sender bursts and receiver stalls mixed, %0d mismatches in %0d cycles",
			board.mismatches, cycle_count);
		if (board.mismatches == 0)
			$display("divider_64_with_remainder test passed");
		else
			$display("divider_64_with_remainder test failed");
		$finish;
	end

endmodule
